[src/rtlk_pkg.sv]
// Shared types and codes for the recursive ticket lock.
// No dependencies; imported by the interfaces, controller, datapath and top level.
package rtlk_pkg;

   localparam int KIND_W  = 3;
   localparam int CPU_W   = 3;
   localparam int COUNT_W = 16;
   localparam int DOUT_W  = 17;
   localparam int TICKET_W = 32;

   localparam logic [KIND_W-1:0] KIND_LOCK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UNLOCK   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REL_ALL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REL_ONE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACQ_CNT  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_POLL     = 3'd5;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [CPU_W-1:0]    cpu_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [TICKET_W-1:0] ticket_type;
   typedef logic signed [DOUT_W-1:0] dout_type;

   typedef struct packed {
      logic capture;
      logic exec;
   } ctrl_cmd_type;

endpackage

[src/rtlk_req_if.sv]
// Request channel: valid/ready handshake carrying one request word.
// Depends on rtlk_pkg for the field types.
interface rtlk_req_if;
   import rtlk_pkg::*;
   logic      valid;
   logic      ready;
   kind_type  kind;
   cpu_type   cpu;
   count_type count;

   modport source (output valid, output kind, output cpu, output count, input ready);
   modport sink (input valid, input kind, input cpu, input count, output ready);
endinterface

[src/rtlk_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result word.
// Depends on rtlk_pkg for the field types.
interface rtlk_rsp_if;
   import rtlk_pkg::*;
   logic       valid;
   logic       ready;
   logic       granted;
   dout_type   depth_out;
   ticket_type ticket;
   logic       error;

   modport source (output valid, output granted, output depth_out, output ticket,
                   output error, input ready);
   modport sink (input valid, input granted, input depth_out, input ticket,
                 input error, output ready);
endinterface

[src/rtlk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtlk_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[src/rtlk_ctrl.sv]
// Controller: sequences accept, update and response of one request word.
// Depends on rtlk_pkg for the command struct.
module rtlk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rtlk_pkg::ctrl_cmd_type cmd
);
   import rtlk_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec    = (state_ff == ST_EXEC);
endmodule

[src/rtlk_dp.sv]
// Datapath: ticket counters, per-processor entry RAM with valid bits, result regs.
// Depends on rtlk_pkg and rtlk_ram.
module rtlk_dp #(
   parameter int NUM_CPUS   = 8,
   parameter int DEPTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rtlk_pkg::ctrl_cmd_type cmd,
   input  rtlk_pkg::kind_type     req_kind,
   input  rtlk_pkg::cpu_type      req_cpu,
   input  rtlk_pkg::count_type    req_count,
   output logic                   rsp_granted,
   output rtlk_pkg::dout_type     rsp_depth_out,
   output rtlk_pkg::ticket_type   rsp_ticket,
   output logic                   rsp_error
);
   import rtlk_pkg::*;

   localparam int IDX_W   = $clog2(NUM_CPUS);
   localparam int ENTRY_W = DEPTH_BITS + TICKET_W;
   localparam int SUM_W   = ((DEPTH_BITS > COUNT_W) ? DEPTH_BITS : COUNT_W) + 1;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX  = '1;
   localparam logic [DEPTH_BITS-1:0] DEPTH_ZERO = '0;
   localparam logic [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);

   kind_type          kind_ff;
   logic [IDX_W-1:0]  idx_ff;
   count_type         count_ff;
   logic              in_range_ff;
   ticket_type        next_ticket_ff, next_ticket_in;
   ticket_type        now_serving_ff, now_serving_in;
   logic [NUM_CPUS-1:0] valid_ff;
   logic              granted_ff, granted_in;
   dout_type          dout_ff, dout_in;
   ticket_type        ticket_ff, ticket_in;
   logic              error_ff, error_in;

   logic [ENTRY_W-1:0]    rd_data;
   logic [DEPTH_BITS-1:0] cur_depth;
   ticket_type            cur_ticket;
   logic [DEPTH_BITS-1:0] new_depth;
   ticket_type            new_ticket;
   logic [SUM_W-1:0]      acq_sum;
   logic                  entry_we;

   rtlk_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CPUS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (idx_ff),
      .wr_data ({new_ticket, new_depth}),
      .rd_addr (IDX_W'(req_cpu)),
      .rd_data (rd_data)
   );

   assign cur_depth  = valid_ff[idx_ff] ? rd_data[DEPTH_BITS-1:0] : DEPTH_ZERO;
   assign cur_ticket = valid_ff[idx_ff] ? rd_data[ENTRY_W-1:DEPTH_BITS] : '0;
   assign acq_sum    = SUM_W'(cur_depth) + SUM_W'(count_ff);
   assign entry_we   = cmd.exec && in_range_ff;

   always_comb begin
      new_depth      = cur_depth;
      new_ticket     = cur_ticket;
      next_ticket_in = next_ticket_ff;
      now_serving_in = now_serving_ff;
      error_in       = 1'b0;
      dout_in        = DOUT_W'(cur_depth);
      case (kind_ff)
         KIND_LOCK: begin
            if (cur_depth == DEPTH_MAX) begin
               error_in = 1'b1;
            end else begin
               if (cur_depth == DEPTH_ZERO) begin
                  new_ticket     = next_ticket_ff;
                  next_ticket_in = next_ticket_ff + 1'b1;
               end
               new_depth = cur_depth + 1'b1;
            end
            dout_in = DOUT_W'(new_depth);
         end
         KIND_UNLOCK: begin
            if (cur_depth == DEPTH_ZERO) begin
               error_in = 1'b1;
            end else begin
               new_depth = cur_depth - 1'b1;
               if (cur_depth == DEPTH_ONE) now_serving_in = now_serving_ff + 1'b1;
            end
            dout_in = DOUT_W'(new_depth);
         end
         KIND_REL_ALL: begin
            new_depth      = DEPTH_ZERO;
            now_serving_in = now_serving_ff + 1'b1;
         end
         KIND_REL_ONE: begin
            new_depth = DEPTH_ONE;
            dout_in   = DOUT_W'(cur_depth) - 1'b1;
         end
         KIND_ACQ_CNT: begin
            if (count_ff != '0) begin
               if (cur_depth == DEPTH_ZERO) begin
                  new_ticket     = next_ticket_ff;
                  next_ticket_in = next_ticket_ff + 1'b1;
               end
               if (acq_sum > SUM_W'(DEPTH_MAX)) begin
                  new_depth = DEPTH_MAX;
                  error_in  = 1'b1;
               end else begin
                  new_depth = acq_sum[DEPTH_BITS-1:0];
               end
            end
            dout_in = DOUT_W'(new_depth);
         end
         default: begin
         end
      endcase
      granted_in = (new_ticket == now_serving_in) && (new_depth != DEPTH_ZERO);
      ticket_in  = new_ticket;
      if (!in_range_ff) begin
         granted_in     = 1'b0;
         dout_in        = '0;
         ticket_in      = '0;
         error_in       = 1'b1;
         next_ticket_in = next_ticket_ff;
         now_serving_in = now_serving_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff     <= req_kind;
         idx_ff      <= IDX_W'(req_cpu);
         count_ff    <= req_count;
         in_range_ff <= (32'(req_cpu) < 32'(NUM_CPUS));
      end
      if (cmd.exec) begin
         granted_ff <= granted_in;
         dout_ff    <= dout_in;
         ticket_ff  <= ticket_in;
         error_ff   <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ticket_ff <= '0;
         now_serving_ff <= '0;
         valid_ff       <= '0;
      end else if (cmd.exec) begin
         next_ticket_ff <= next_ticket_in;
         now_serving_ff <= now_serving_in;
         if (entry_we) valid_ff[idx_ff] <= 1'b1;
      end
   end

   assign rsp_granted   = granted_ff;
   assign rsp_depth_out = dout_ff;
   assign rsp_ticket    = ticket_ff;
   assign rsp_error     = error_ff;
endmodule

[src/recursive_ticket_lock_top.sv]
// Recursive ticket lock shared by NUM_CPUS processors. Each request word names a
// processor and an operation (lock, unlock, release all, release all but one,
// acquire count, held poll) and returns exactly one result word with the granted
// flag, the depth, the processor's ticket and an error flag. Callers spin by
// polling granted. Requests are handled one at a time: the accept cycle captures the
// word and starts the registered read of the per-processor entry RAM, the update
// cycle writes the entry and loads the result, and the result is then presented
// until rsp ready is high. The next request is taken in the cycle after the result
// is taken. Reset clears all entries at once through per-processor valid bits; no
// clearing pass is needed.
// Depends on rtlk_pkg, rtlk_req_if, rtlk_rsp_if, rtlk_ctrl, rtlk_dp, rtlk_ram.
module recursive_ticket_lock_top #(
   parameter int NUM_CPUS   = 8,
   parameter int DEPTH_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   rtlk_req_if.sink  req,
   rtlk_rsp_if.source rsp
);
   import rtlk_pkg::*;

   ctrl_cmd_type cmd;

   rtlk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   rtlk_dp #(.NUM_CPUS(NUM_CPUS), .DEPTH_BITS(DEPTH_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req.kind),
      .req_cpu       (req.cpu),
      .req_count     (req.count),
      .rsp_granted   (rsp.granted),
      .rsp_depth_out (rsp.depth_out),
      .rsp_ticket    (rsp.ticket),
      .rsp_error     (rsp.error)
   );
endmodule
